[hdl/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg - shared types and constants of the Gaussian density evaluator
// Word formats, register codes, fixed-point widths and the power-of-two
// table used by the exponent stages.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int NUM_DIMS = 4;
  localparam int MAX_DIMS = 4;
  localparam int LANE_W   = $clog2(MAX_DIMS);

  localparam int VAL_W   = 16;
  localparam int SIG_W   = 15;
  localparam int AD_W    = 16;
  localparam int SQ_W    = 30;
  localparam int NUM_W   = 32;
  localparam int QUO_W   = 48;
  localparam int ESUM_W  = QUO_W + 2;
  localparam int E_W     = 39;
  localparam int E_SPLIT = 20;
  localparam int C_W     = 25;
  localparam int T_W     = 46;
  localparam int L_W     = 48;
  localparam int FRAC_W  = 24;
  localparam int K_W     = 5;
  localparam int KK_W    = 4;
  localparam int LG_W    = KK_W + FRAC_W;
  localparam int LGS_W   = 30;
  localparam int M_W     = 31;
  localparam int P_W     = 31;
  localparam int DENS_W  = 32;

  localparam logic [C_W-1:0] LOG2E_Q24 = C_W'(24204406);
  localparam longint HALF_LOG2_2PI_Q24 = 22242362;

  localparam longint L_BASE_I = (longint'(16 + 8 * NUM_DIMS) <<< 24)
                                - longint'(NUM_DIMS) * HALF_LOG2_2PI_Q24;
  localparam logic signed [L_W-1:0] L_BASE = L_W'(L_BASE_I);
  localparam logic signed [L_W-1:0] L_SAT  = L_W'(longint'(32) <<< 24);

  localparam logic [LG_W-1:0]  LG_RESET    = LG_W'(longint'(8) <<< 24);
  localparam logic [LGS_W-1:0] LGSUM_RESET = LGS_W'(longint'(NUM_DIMS) * (longint'(8) <<< 24));
  localparam logic [SQ_W-1:0]  SQ_RESET    = SQ_W'(256 * 256);

  // stage counts: lane = |d| reg, square reg, one divider stage per quotient bit
  localparam int LANE_LAT  = 2 + QUO_W;
  localparam int MERGE_LAT = 4 + FRAC_W + 1;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_dim0;
    logic signed [VAL_W-1:0] value_dim1;
    logic signed [VAL_W-1:0] value_dim2;
    logic signed [VAL_W-1:0] value_dim3;
  } in_word_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              saturated;
  } out_word_t;

  typedef enum logic [2:0] {
    CFG_MEAN_DIM0  = 3'd0,
    CFG_SIGMA_DIM0 = 3'd1,
    CFG_MEAN_DIM1  = 3'd2,
    CFG_SIGMA_DIM1 = 3'd3,
    CFG_MEAN_DIM2  = 3'd4,
    CFG_SIGMA_DIM2 = 3'd5,
    CFG_MEAN_DIM3  = 3'd6,
    CFG_SIGMA_DIM3 = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    cfg_idx_e          index;
    logic [VAL_W-1:0]  data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOG,
    CS_SUM
  } cfg_state_e;

  typedef struct packed {
    logic                             busy;
    logic [MAX_DIMS-1:0][VAL_W-1:0]   mean;
    logic [MAX_DIMS-1:0][SQ_W-1:0]    sq;
    logic [LGS_W-1:0]                 lgsum;
  } cfg_view_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 value of 2^(2^-j), built by repeated integer square roots
  function automatic logic [P_W-1:0] exp_tab(int j);
    logic [63:0] t;
    t = 64'(1) << 31;
    for (int i = 1; i <= FRAC_W; i++) begin
      if (i <= j) begin
        t = isqrt64(t << 30);
      end
    end
    return P_W'(t);
  endfunction

endpackage

[hdl/gaussian_pdf_eval.sv]
// ----------------------------------------------------------------------------
// gaussian_pdf_eval - diagonal Gaussian density, one observation per cycle
// Takes one observation word per cycle while in_ready_o is high and returns
// one density word for each, in order; the depth is set by the per-lane
// restoring divider (one quotient bit per stage) and the 24 table-multiply
// stages that rebuild the power of two. An output register plus a skid word
// keep input taken while a finished word waits. Writing a deviation register
// starts a 24-step log2 on a shared multiplier; inputs and further writes are
// held off until it is done. Mean writes take effect at once.
// ----------------------------------------------------------------------------
module gaussian_pdf_eval import gpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_wr_t   cfg_wr_i
);

  cfg_view_t view;

  logic                           pipe_en;
  logic                           in_acc;
  logic [PIPE_LAT-1:0]            vld_q;
  logic [MAX_DIMS-1:0][VAL_W-1:0] vals;
  logic [NUM_DIMS-1:0][QUO_W-1:0] quo;
  out_word_t                      res;
  logic                           res_v;
  logic                           out_free;

  logic      out_valid_q;
  logic      skid_valid_q;
  out_word_t out_q;
  out_word_t skid_q;

  gpe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wr_i    (cfg_wr_i),
    .view_o      (view)
  );

  assign pipe_en    = ~skid_valid_q;
  assign in_ready_o = pipe_en & ~view.busy;
  assign in_acc     = in_valid_i & in_ready_o;

  assign vals[0] = in_word_i.value_dim0;
  assign vals[1] = in_word_i.value_dim1;
  assign vals[2] = in_word_i.value_dim2;
  assign vals[3] = in_word_i.value_dim3;

  for (genvar i = 0; i < NUM_DIMS; i++) begin : g_lane
    gpe_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .value_i ($signed(vals[i])),
      .mean_i  (view.mean[i]),
      .sq_i    (view.sq[i]),
      .quo_o   (quo[i])
    );
  end

  gpe_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .quo_i   (quo),
    .lgsum_i (view.lgsum),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_acc};
    end
  end

  assign res_v    = vld_q[PIPE_LAT-1];
  assign out_free = ~out_valid_q | out_ready_i;

  // park the leaving word in the skid register when the output is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pipe_en) begin
      if (out_free) begin
        out_valid_q <= res_v;
      end else if (res_v) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_free) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[hdl/gpe_cfg.sv]
// ----------------------------------------------------------------------------
// gpe_cfg - configuration registers and log2 unit
// Holds the means, the squared deviations and the sum of log2 deviations.
// A deviation write runs a 24-step squaring log2 on a shared multiplier.
// ----------------------------------------------------------------------------
module gpe_cfg import gpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_wr_t   cfg_wr_i,
  output cfg_view_t view_o
);

  cfg_state_e state_q, state_d;

  logic [MAX_DIMS-1:0][VAL_W-1:0] mean_q;
  logic [MAX_DIMS-1:0][SQ_W-1:0]  sq_q;
  logic [MAX_DIMS-1:0][LG_W-1:0]  lg_q;
  logic [LGS_W-1:0]               lgsum_q;

  logic [LANE_W-1:0] lane_q;
  logic [4:0]        cnt_q;
  logic [M_W-1:0]    m_q;
  logic [FRAC_W-1:0] frac_q;
  logic [KK_W-1:0]   kk_q;

  logic              wr;
  logic              is_sigma;
  logic [LANE_W-1:0] lane;
  logic [SIG_W-1:0]  s_eff;
  logic [KK_W-1:0]   lead;
  logic [M_W-1:0]    m_init;
  logic [SQ_W-1:0]   sq_new;
  logic [61:0]       mm;
  logic [31:0]       msq;
  logic              fbit;
  logic [M_W-1:0]    m_next;
  logic [FRAC_W-1:0] frac_next;
  logic [LGS_W-1:0]  lg_total;

  assign cfg_ready_o = (state_q == CS_IDLE);
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    is_sigma = 1'b0;
    lane     = '0;
    unique case (cfg_wr_i.index)
      CFG_MEAN_DIM0:  begin lane = LANE_W'(0); is_sigma = 1'b0; end
      CFG_SIGMA_DIM0: begin lane = LANE_W'(0); is_sigma = 1'b1; end
      CFG_MEAN_DIM1:  begin lane = LANE_W'(1); is_sigma = 1'b0; end
      CFG_SIGMA_DIM1: begin lane = LANE_W'(1); is_sigma = 1'b1; end
      CFG_MEAN_DIM2:  begin lane = LANE_W'(2); is_sigma = 1'b0; end
      CFG_SIGMA_DIM2: begin lane = LANE_W'(2); is_sigma = 1'b1; end
      CFG_MEAN_DIM3:  begin lane = LANE_W'(3); is_sigma = 1'b0; end
      CFG_SIGMA_DIM3: begin lane = LANE_W'(3); is_sigma = 1'b1; end
      default:        begin lane = '0; is_sigma = 1'b0; end
    endcase
  end

  // zero deviation counts as the smallest step
  always_comb begin
    s_eff = (cfg_wr_i.data[SIG_W-1:0] == '0) ? SIG_W'(1) : cfg_wr_i.data[SIG_W-1:0];
    lead  = '0;
    for (int b = 0; b < SIG_W; b++) begin
      if (s_eff[b]) lead = KK_W'(b);
    end
    m_init = M_W'(s_eff) << (5'd30 - {1'b0, lead});
    sq_new = SQ_W'(s_eff) * SQ_W'(s_eff);
  end

  always_comb begin
    mm        = 62'(m_q) * 62'(m_q);
    msq       = mm[61:30];
    fbit      = msq[31];
    m_next    = fbit ? msq[31:1] : msq[30:0];
    frac_next = {frac_q[FRAC_W-2:0], fbit};
  end

  always_comb begin
    lg_total = '0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      lg_total = lg_total + LGS_W'(lg_q[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (wr && is_sigma) state_d = CS_LOG;
      CS_LOG:  if (cnt_q == 5'(FRAC_W - 1)) state_d = CS_SUM;
      CS_SUM:  state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      for (int i = 0; i < MAX_DIMS; i++) begin
        mean_q[i] <= '0;
        sq_q[i]   <= SQ_RESET;
        lg_q[i]   <= LG_RESET;
      end
      lgsum_q <= LGSUM_RESET;
      lane_q  <= '0;
      cnt_q   <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      kk_q    <= '0;
    end else begin
      state_q <= state_d;
      if (wr) begin
        if (is_sigma) begin
          sq_q[lane] <= sq_new;
          lane_q     <= lane;
          m_q        <= m_init;
          kk_q       <= lead;
          cnt_q      <= '0;
          frac_q     <= '0;
        end else begin
          mean_q[lane] <= cfg_wr_i.data;
        end
      end
      if (state_q == CS_LOG) begin
        m_q    <= m_next;
        frac_q <= frac_next;
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'(FRAC_W - 1)) begin
          lg_q[lane_q] <= {kk_q, frac_next};
        end
      end
      if (state_q == CS_SUM) begin
        lgsum_q <= lg_total;
      end
    end
  end

  assign view_o.busy  = (state_q != CS_IDLE);
  assign view_o.mean  = mean_q;
  assign view_o.sq    = sq_q;
  assign view_o.lgsum = lgsum_q;

endmodule

[hdl/gpe_lane.sv]
// ----------------------------------------------------------------------------
// gpe_lane - one dimension of the squared normalised distance
// Takes |x - m|, squares it and divides by sigma^2 in a restoring
// divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module gpe_lane import gpe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [VAL_W-1:0]        mean_i,
  input  logic [SQ_W-1:0]         sq_i,
  output logic [QUO_W-1:0]        quo_o
);

  logic signed [VAL_W:0] diff;
  logic [AD_W-1:0]       ad_d;
  logic [AD_W-1:0]       ad_q;
  logic [NUM_W-1:0]      num_q;

  logic [SQ_W-1:0]  rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [NUM_W-1:0] num_s_q [NUM_W-1];

  assign diff = {value_i[VAL_W-1], value_i} - $signed({mean_i[VAL_W-1], mean_i});
  assign ad_d = diff[VAL_W] ? AD_W'(-diff) : diff[AD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ad_q  <= ad_d;
      num_q <= NUM_W'(ad_q) * NUM_W'(ad_q);
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [SQ_W-1:0]  rem_in;
    logic [QUO_W-1:0] quo_in;
    logic             nb;
    logic [SQ_W:0]    trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // the dividend is the square shifted up by 16: low bits bring in zeros
    if (j == 0) begin : g_nb_first
      assign nb = num_q[NUM_W-1];
    end else if (j < NUM_W) begin : g_nb_num
      assign nb = num_s_q[j-1][NUM_W-1-j];
    end else begin : g_nb_zero
      assign nb = 1'b0;
    end

    assign trial = {rem_in, nb};
    assign ge    = (trial >= {1'b0, sq_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? SQ_W'(trial - {1'b0, sq_i}) : trial[SQ_W-1:0];
        quo_q[j] <= {quo_in[QUO_W-2:0], ge};
      end
    end

    if (j < NUM_W - 1) begin : g_num
      if (j == 0) begin : g_num_first
        always_ff @(posedge clk_i) begin
          if (en_i) num_s_q[j] <= num_q;
        end
      end else begin : g_num_next
        always_ff @(posedge clk_i) begin
          if (en_i) num_s_q[j] <= num_s_q[j-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

[hdl/gpe_merge.sv]
// ----------------------------------------------------------------------------
// gpe_merge - combine lanes into the density
// Sums and clamps the lane results, scales into the base-2 log domain,
// then rebuilds 2^L with one table multiply per fraction bit.
// ----------------------------------------------------------------------------
module gpe_merge import gpe_pkg::*; (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [NUM_DIMS-1:0][QUO_W-1:0] quo_i,
  input  logic [LGS_W-1:0]               lgsum_i,
  output out_word_t                      res_o
);

  typedef struct packed {
    logic              sat;
    logic              zero;
    logic [K_W-1:0]    k;
    logic [FRAC_W-1:0] f;
  } exp_ctl_t;

  localparam logic [ESUM_W-1:0] E_CLAMP = ESUM_W'(64'(1) << (E_W - 1));

  logic [ESUM_W-1:0]           e_sum;
  logic [E_W-1:0]              e_q;
  logic [E_W-E_SPLIT+C_W-1:0]  ph_q;
  logic [E_SPLIT+C_W-1:0]      pl_q;
  logic [64:0]                 prod;
  logic [T_W-1:0]              t_q;
  logic signed [L_W-1:0]       l_d;
  exp_ctl_t                    ctl_d;
  exp_ctl_t                    ctl0_q;

  exp_ctl_t       ctl_q [FRAC_W];
  logic [P_W-1:0] p_q   [FRAC_W];

  logic [K_W-1:0]    shamt;
  logic [DENS_W-1:0] dens;
  out_word_t         res_q;

  always_comb begin
    e_sum = '0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      e_sum = e_sum + ESUM_W'(quo_i[i]);
    end
  end

  assign prod = 65'({ph_q, E_SPLIT'(0)}) + 65'(pl_q);

  always_comb begin
    l_d = L_BASE - $signed({(L_W - LGS_W)'(0), lgsum_i}) - $signed({(L_W - T_W)'(0), t_q});
    ctl_d.sat  = (l_d >= L_SAT);
    ctl_d.zero = l_d[L_W-1];
    ctl_d.k    = l_d[FRAC_W+K_W-1:FRAC_W];
    ctl_d.f    = l_d[FRAC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= (e_sum > E_CLAMP) ? E_W'(E_CLAMP) : e_sum[E_W-1:0];
      ph_q   <= (E_W-E_SPLIT+C_W)'(e_q[E_W-1:E_SPLIT]) * (E_W-E_SPLIT+C_W)'(LOG2E_Q24);
      pl_q   <= (E_SPLIT+C_W)'(e_q[E_SPLIT-1:0]) * (E_SPLIT+C_W)'(LOG2E_Q24);
      t_q    <= T_W'(prod >> 17);
      ctl0_q <= ctl_d;
    end
  end

  // stage s applies fraction bit (FRAC_W-1-s), weight 2^(2^-(s+1))
  for (genvar s = 0; s < FRAC_W; s++) begin : g_exp
    localparam logic [P_W-1:0] TJ = exp_tab(s + 1);
    exp_ctl_t       ctl_in;
    logic [P_W-1:0] p_in;
    logic [61:0]    pr;

    if (s == 0) begin : g_first
      assign ctl_in = ctl0_q;
      assign p_in   = P_W'(64'(1) << 30);
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign p_in   = p_q[s-1];
    end

    assign pr = 62'(p_in) * 62'(TJ);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[s] <= ctl_in;
        p_q[s]   <= ctl_in.f[FRAC_W-1-s] ? pr[60:30] : p_in;
      end
    end
  end

  always_comb begin
    shamt = K_W'(30) - ctl_q[FRAC_W-1].k;
    if (ctl_q[FRAC_W-1].k == K_W'(31)) begin
      dens = {p_q[FRAC_W-1], 1'b0};
    end else begin
      dens = DENS_W'(p_q[FRAC_W-1]) >> shamt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctl_q[FRAC_W-1].sat) begin
        res_q.density   <= '1;
        res_q.saturated <= 1'b1;
      end else if (ctl_q[FRAC_W-1].zero) begin
        res_q.density   <= '0;
        res_q.saturated <= 1'b0;
      end else begin
        res_q.density   <= dens;
        res_q.saturated <= 1'b0;
      end
    end
  end

  assign res_o = res_q;

endmodule
